/* src/ptd_pkg.sv */
// shared constants and types for the probe temperature decoder
package ptd_pkg;

  // internal sensors carried in the newer payload, 1 to 5
  localparam int NumSensors = 5;

  localparam int WordW  = 16;
  localparam int LenW   = 8;
  localparam int LaneW  = WordW + 1;
  localparam int TipW   = 19;
  localparam int AmbW   = 21;

  localparam int ProMinLen  = 12;
  localparam int OrigMinLen = 6;
  localparam int MoveOff    = 8;
  localparam int AmbClamp   = 48;
  localparam int ClampW     = 6;

  // ambient scale factor is 16 * 589 / 1487
  localparam int AmbMul = 16 * 589;
  localparam int AmbDiv = 1487;
  localparam int ProdW  = 30;
  localparam int QuotW  = 19;

  // reciprocal of the divisor, exact floor for any ProdW-bit dividend
  localparam int AmbShift = ProdW + 11;
  localparam longint unsigned AmbRecip =
    ((64'd1 << AmbShift) + AmbDiv - 1) / AmbDiv;
  localparam int RecipW = 31;

  typedef logic [WordW-1:0]        word_t;
  typedef logic signed [LaneW-1:0] lane_t;

  // load enables of the ambient scaling stages
  typedef struct packed {
    logic ld_b;
    logic ld_c;
  } ptd_adv_t;

endpackage

/* src/probe_temperature_decode.sv */
// probe temperature decoder top level
// Takes one beat per clock while in_ready is high and returns one result beat per input
// beat, in order; the pipeline depth is set by the registers of the ambient scaling path
// (input stage, constant multiply, reciprocal multiply, output register). Sensor words go
// through parallel lanes merged by a min stage. The format bit is sampled when a beat is
// accepted. Each stage has its own ready, so bubbles close up while the output is stalled.
module probe_temperature_decode (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ptd_pkg::WordW-1:0]       in_word0,
  input  logic [ptd_pkg::WordW-1:0]       in_word1,
  input  logic [ptd_pkg::WordW-1:0]       in_word2,
  input  logic [ptd_pkg::WordW-1:0]       in_word3,
  input  logic [ptd_pkg::WordW-1:0]       in_word4,
  input  logic [ptd_pkg::WordW-1:0]       in_word5,
  input  logic [ptd_pkg::LenW-1:0]        in_payload_length,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [ptd_pkg::TipW-1:0] out_tip_temp,
  output logic signed [ptd_pkg::AmbW-1:0] out_ambient_temp,
  output logic                            out_reading_valid
);
  import ptd_pkg::*;

  word_t words [6];
  lane_t lane_val [NumSensors];
  lane_t amb_val;
  lane_t lane_min;

  logic gen_r, gen_nxt;
  logic a_vld_r, a_vld_nxt, b_vld_r, b_vld_nxt, c_vld_r, c_vld_nxt;
  logic out_vld_r, out_vld_nxt;
  logic a_load, b_load, c_load, out_load;
  ptd_adv_t adv;

  // stage a
  lane_t a_lane_r [NumSensors];
  lane_t a_amb_r;
  word_t a_t_r;
  word_t a_d_r;
  logic  a_gen_r;
  logic  a_ok_r;
  // stage b
  lane_t b_min_r;
  lane_t b_amb_r;
  word_t b_t_r;
  logic  b_gen_r;
  logic  b_ok_r;
  // stage c
  lane_t c_min_r;
  lane_t c_amb_r;
  word_t c_t_r;
  logic  c_gen_r;
  logic  c_ok_r;
  logic [QuotW-1:0] c_q;
  // output
  logic signed [TipW-1:0] tip_r, tip_nxt;
  logic signed [AmbW-1:0] amb_r, amb_nxt;
  logic                   ok_r;

  logic [ClampW-1:0] lim;
  logic [LaneW-1:0]  diff;
  word_t             d_val;
  logic              len_ok;
  logic [LaneW-1:0]  tip_sum;
  logic [AmbW-2:0]   amb_sum;

  assign words[0] = in_word0;
  assign words[1] = in_word1;
  assign words[2] = in_word2;
  assign words[3] = in_word3;
  assign words[4] = in_word4;
  assign words[5] = in_word5;

  for (genvar g = 0; g < NumSensors; g++) begin : g_lane
    ptd_lane u_lane (
      .word_i (words[g]),
      .val_o  (lane_val[g])
    );
  end

  ptd_lane u_amb_lane (
    .word_i (words[5]),
    .val_o  (amb_val)
  );

  ptd_merge u_merge (
    .lane_i (a_lane_r),
    .min_o  (lane_min)
  );

  // per-stage ready chain
  always_comb begin
    out_load = !out_vld_r || out_ready;
    c_load   = !c_vld_r || out_load;
    b_load   = !b_vld_r || c_load;
    a_load   = !a_vld_r || b_load;
  end

  assign in_ready   = a_load;
  assign adv.ld_b   = b_load;
  assign adv.ld_c   = c_load;

  always_comb begin
    gen_nxt     = cfg_wr_en ? cfg_wr_data : gen_r;
    a_vld_nxt   = a_load   ? in_valid  : a_vld_r;
    b_vld_nxt   = b_load   ? a_vld_r   : b_vld_r;
    c_vld_nxt   = c_load   ? b_vld_r   : c_vld_r;
    out_vld_nxt = out_load ? c_vld_r   : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r     <= 1'b0;
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      gen_r     <= gen_nxt;
      a_vld_r   <= a_vld_nxt;
      b_vld_r   <= b_vld_nxt;
      c_vld_r   <= c_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // original format ambient rise, clamped at zero, and the length check for either format
  always_comb begin
    lim    = (in_word2 < WordW'(AmbClamp)) ? in_word2[ClampW-1:0] : ClampW'(AmbClamp);
    diff   = {1'b0, in_word1} - LaneW'(lim);
    d_val  = diff[LaneW-1] ? '0 : diff[WordW-1:0];
    len_ok = gen_r ? (in_payload_length >= LenW'(ProMinLen))
                   : (in_payload_length >= LenW'(OrigMinLen));
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_lane_r <= lane_val;
      a_amb_r  <= amb_val;
      a_t_r    <= in_word0;
      a_d_r    <= d_val;
      a_gen_r  <= gen_r;
      a_ok_r   <= len_ok;
    end
    if (b_load) begin
      b_min_r <= lane_min;
      b_amb_r <= a_amb_r;
      b_t_r   <= a_t_r;
      b_gen_r <= a_gen_r;
      b_ok_r  <= a_ok_r;
    end
    if (c_load) begin
      c_min_r <= b_min_r;
      c_amb_r <= b_amb_r;
      c_t_r   <= b_t_r;
      c_gen_r <= b_gen_r;
      c_ok_r  <= b_ok_r;
    end
    if (out_load) begin
      tip_r <= tip_nxt;
      amb_r <= amb_nxt;
      ok_r  <= c_ok_r;
    end
  end

  ptd_amb_scale u_amb_scale (
    .clk   (clk),
    .adv_i (adv),
    .d_i   (a_d_r),
    .q_o   (c_q)
  );

  always_comb begin
    tip_sum = {1'b0, c_t_r} + LaneW'(MoveOff);
    amb_sum = (AmbW-1)'(c_t_r) + (AmbW-1)'(c_q) + (AmbW-1)'(MoveOff);
    if (!c_ok_r) begin
      tip_nxt = '0;
      amb_nxt = '0;
    end else if (c_gen_r) begin
      tip_nxt = TipW'(c_min_r);
      amb_nxt = AmbW'(c_amb_r);
    end else begin
      tip_nxt = signed'({1'b0, tip_sum, 1'b0});
      amb_nxt = signed'({amb_sum, 1'b0});
    end
  end

  assign out_valid         = out_vld_r;
  assign out_tip_temp      = tip_r;
  assign out_ambient_temp  = amb_r;
  assign out_reading_valid = ok_r;

endmodule

/* src/ptd_lane.sv */
// one sensor lane: moves a signed reading 8 away from zero
module ptd_lane (
  input  ptd_pkg::word_t word_i,
  output ptd_pkg::lane_t val_o
);
  import ptd_pkg::*;

  lane_t ext;

  always_comb begin
    ext = lane_t'(signed'(word_i));
    if (word_i == '0) begin
      val_o = '0;
    end else if (word_i[WordW-1]) begin
      val_o = ext - lane_t'(MoveOff);
    end else begin
      val_o = ext + lane_t'(MoveOff);
    end
  end

endmodule

/* src/ptd_merge.sv */
// merge stage: least of the lane readings
module ptd_merge (
  input  ptd_pkg::lane_t lane_i [ptd_pkg::NumSensors],
  output ptd_pkg::lane_t min_o
);
  import ptd_pkg::*;

  always_comb begin
    min_o = lane_i[0];
    for (int i = 1; i < NumSensors; i++) begin
      if (lane_i[i] < min_o) begin
        min_o = lane_i[i];
      end
    end
  end

endmodule

/* src/ptd_amb_scale.sv */
// ambient rise scaling: floor(d * 9424 / 1487) over two registered stages
module ptd_amb_scale (
  input  logic                      clk,
  input  ptd_pkg::ptd_adv_t         adv_i,
  input  ptd_pkg::word_t            d_i,
  output logic [ptd_pkg::QuotW-1:0] q_o
);
  import ptd_pkg::*;

  logic [ProdW-1:0]        prod_r;
  logic [ProdW+RecipW-1:0] recip_prod;
  logic [QuotW-1:0]        q_r;

  // multiply by reciprocal and shift replaces the constant divide
  assign recip_prod = (ProdW+RecipW)'(prod_r) * (ProdW+RecipW)'(AmbRecip);

  always_ff @(posedge clk) begin
    if (adv_i.ld_b) begin
      prod_r <= ProdW'(d_i) * ProdW'(AmbMul);
    end
    if (adv_i.ld_c) begin
      q_r <= recip_prod[AmbShift +: QuotW];
    end
  end

  assign q_o = q_r;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for the probe temperature decoder, both payload formats
module tb;
  import ptd_pkg::*;

  typedef struct packed {
    logic [5:0][WordW-1:0] words;
    logic [LenW-1:0]       len;
  } payload_t;

  typedef struct packed {
    logic signed [TipW-1:0] tip;
    logic signed [AmbW-1:0] amb;
    logic                   ok;
  } reading_t;

  class probe_reading_sb;
    reading_t expected_readings[$];
    int       errors = 0;

    static function longint away_from_zero(logic signed [WordW-1:0] r);
      longint v;
      v = r;
      if (v > 0) return v + MoveOff;
      if (v < 0) return v - MoveOff;
      return 0;
    endfunction

    static function reading_t predict_reading(payload_t p, bit pro);
      reading_t r;
      longint t, ra, oa, lim, d, add, mn, c, tip, amb;
      r = '0;
      if (pro) begin
        if (p.len >= ProMinLen) begin
          mn = 0;
          for (int i = 0; i < NumSensors; i++) begin
            c = away_from_zero(p.words[i]);
            if (i == 0 || c < mn) mn = c;
          end
          amb = away_from_zero(p.words[5]);
          r.tip = mn[TipW-1:0];
          r.amb = amb[AmbW-1:0];
          r.ok = 1'b1;
        end
      end else if (p.len >= OrigMinLen) begin
        t = p.words[0];
        ra = p.words[1];
        oa = p.words[2];
        lim = (oa < AmbClamp) ? oa : AmbClamp;
        d = ra - lim;
        add = 0;
        // exact floor of the scaled raw-minus-offset difference
        if (d > 0) add = (d * AmbMul) / AmbDiv;
        tip = 2 * (t + MoveOff);
        amb = 2 * (t + add + MoveOff);
        r.tip = tip[TipW-1:0];
        r.amb = amb[AmbW-1:0];
        r.ok = 1'b1;
      end
      return r;
    endfunction

    function void note_payload(payload_t p, bit pro);
      expected_readings.push_back(predict_reading(p, pro));
    endfunction

    function void check_reading(logic signed [TipW-1:0] tip, logic signed [AmbW-1:0] amb,
                                logic ok);
      reading_t e;
      if (expected_readings.size() == 0) begin
        $error("result beat with nothing expected: tip_temp %0d ambient_temp %0d valid %0b",
               tip, amb, ok);
        errors++;
        return;
      end
      e = expected_readings.pop_front();
      if (tip !== e.tip) begin
        $error("tip_temp mismatch: expected %0d, actual %0d", e.tip, tip);
        errors++;
      end
      if (amb !== e.amb) begin
        $error("ambient_temp mismatch: expected %0d, actual %0d", e.amb, amb);
        errors++;
      end
      if (ok !== e.ok) begin
        $error("reading_valid mismatch: expected %0b, actual %0b", e.ok, ok);
        errors++;
      end
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;
  logic in_valid;
  logic in_ready;
  logic [WordW-1:0] in_word0, in_word1, in_word2, in_word3, in_word4, in_word5;
  logic [LenW-1:0] in_payload_length;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [TipW-1:0] out_tip_temp;
  logic signed [AmbW-1:0] out_ambient_temp;
  logic out_reading_valid;

  probe_reading_sb sb;
  bit gen_pro;
  bit steady = 1'b0;

  probe_temperature_decode dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_word0         (in_word0),
    .in_word1         (in_word1),
    .in_word2         (in_word2),
    .in_word3         (in_word3),
    .in_word4         (in_word4),
    .in_word5         (in_word5),
    .in_payload_length(in_payload_length),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tip_temp     (out_tip_temp),
    .out_ambient_temp (out_ambient_temp),
    .out_reading_valid(out_reading_valid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 10);
  end

  // beat monitor: the format bit is taken at input acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      gen_pro = 1'b0;
    end else begin
      if (in_valid && in_ready)
        sb.note_payload({in_word5, in_word4, in_word3, in_word2, in_word1, in_word0,
                         in_payload_length}, gen_pro);
      if (cfg_wr_en) gen_pro = cfg_wr_data;
      if (out_valid && out_ready)
        sb.check_reading(out_tip_temp, out_ambient_temp, out_reading_valid);
    end
  end

  function automatic payload_t mk(logic [WordW-1:0] w0, logic [WordW-1:0] w1,
                                  logic [WordW-1:0] w2, logic [WordW-1:0] w3,
                                  logic [WordW-1:0] w4, logic [WordW-1:0] w5,
                                  logic [LenW-1:0] len);
    payload_t p;
    p.words = {w5, w4, w3, w2, w1, w0};
    p.len = len;
    return p;
  endfunction

  function automatic logic [WordW-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return WordW'($urandom_range(1, 64));
      2: return WordW'(0 - $urandom_range(1, 64));
      3: return 16'h8000;
      4: return 16'h7FFF;
      default: return WordW'($urandom);
    endcase
  endfunction

  function automatic logic [LenW-1:0] rand_length(bit pro);
    int lo;
    lo = pro ? ProMinLen : OrigMinLen;
    case ($urandom_range(0, 19))
      0, 1: return LenW'($urandom_range(0, lo - 1));
      2: return 8'hFF;
      3: return LenW'($urandom_range(0, 255));
      default: return LenW'($urandom_range(lo, 255));
    endcase
  endfunction

  task automatic send_payload(payload_t p);
    if (!steady && $urandom_range(0, 99) < 4) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_word5, in_word4, in_word3, in_word2, in_word1, in_word0} <= p.words;
    in_payload_length <= p.len;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    // let the last accepted beat be noted before waiting on the scoreboard
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_format(bit pro);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= pro;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_phase(bit pro, int n);
    payload_t p;
    for (int k = 0; k < n; k++) begin
      steady = (k >= 60 && k < 140);
      if (k == n / 2) drain();
      if (pro) begin
        for (int i = 0; i < 6; i++) p.words[i] = rand_word();
      end else begin
        p.words[0] = rand_word();
        // raw ambient and offset near the clamp half of the time
        p.words[1] = $urandom_range(0, 1) ? WordW'($urandom_range(0, 120)) : rand_word();
        p.words[2] = $urandom_range(0, 1) ? WordW'($urandom_range(0, 100)) : rand_word();
        for (int i = 3; i < 6; i++) p.words[i] = WordW'($urandom);
      end
      p.len = rand_length(pro);
      send_payload(p);
    end
    steady = 1'b0;
  endtask

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_valid = 1'b0;
    {in_word0, in_word1, in_word2, in_word3, in_word4, in_word5} = '0;
    in_payload_length = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // original format, reset value of the format bit
    send_payload(mk(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 8'd6));
    send_payload(mk(16'h1234, 16'h100, 16'h10, 16'h0, 16'h0, 16'h0, 8'd5));
    send_payload(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0));
    send_payload(mk(16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0, 8'd255));
    send_payload(mk(16'd700, 16'd10, 16'd40, 16'hAAAA, 16'h5555, 16'hFFFF, 8'd12));
    send_payload(mk(16'd500, 16'd48, 16'd1000, 16'h0, 16'h0, 16'h0, 8'd6));
    send_payload(mk(16'd500, 16'd49, 16'hFFFF, 16'h0, 16'h0, 16'h0, 8'd7));
    send_payload(mk(16'h8000, 16'd47, 16'd47, 16'h0, 16'h0, 16'h0, 8'd6));
    drain();
    write_format(1'b1);

    // newer format
    send_payload(mk(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 8'd12));
    send_payload(mk(16'h1, 16'h1, 16'h1, 16'h1, 16'h1, 16'h1, 8'd11));
    send_payload(mk(16'h1, 16'h1, 16'h1, 16'h1, 16'h1, 16'h1, 8'd6));
    send_payload(mk(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 8'd255));
    send_payload(mk(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 8'd12));
    send_payload(mk(16'd5, 16'h0, 16'd9, 16'd300, 16'hFFFD, 16'hFFFF, 8'd13));
    send_payload(mk(16'h0, 16'd3, 16'd2, 16'd1, 16'd4, 16'h0, 8'd200));
    send_payload(mk(16'hFFFF, 16'd20, 16'hFFF0, 16'd2, 16'hFFFE, 16'd1, 8'd12));
    send_payload(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0));
    random_phase(1'b1, 200);
    drain();
    write_format(1'b0);
    random_phase(1'b0, 200);
    drain();

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
